### rtl/core/segment_triangle_intersect_defines.svh
// ----------------------------------------------------------------------------
// segment_triangle_intersect assertion macros
// shared concurrent assertion forms for the port checker
// ----------------------------------------------------------------------------
`ifndef SEGMENT_TRIANGLE_INTERSECT_DEFINES_SVH
`define SEGMENT_TRIANGLE_INTERSECT_DEFINES_SVH

// same-cycle property, checked outside reset
`define STI_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle property, checked outside reset
`define STI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/sti_pkg.sv
// ----------------------------------------------------------------------------
// sti_pkg
// widths, types and register indexes of the segment / triangle tester
// ----------------------------------------------------------------------------
`default_nettype none

package sti_pkg;

    localparam int CW     = 32;            // coordinate width
    localparam int FB     = 16;            // fraction bits
    localparam int QW     = FB + 1;        // quotient width
    localparam int DW     = CW + 1;        // coordinate difference
    localparam int PW     = 2 * DW;        // product of two differences
    localparam int NW     = PW + 1;        // cross product component
    localparam int SPLIT  = DW + 1;        // low slice of a cross component
    localparam int PLW    = DW + SPLIT + 1;
    localparam int PHW    = DW + NW - SPLIT;
    localparam int PRW    = DW + NW;       // full dot term
    localparam int SW     = PRW + 2;       // dot product
    localparam int NSTEP  = QW;            // divider steps
    localparam int HPW    = CW + QW + 1;   // vertex times weight
    localparam int HSW    = HPW + 2;       // weighted vertex sum
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int NREG   = 6;
    localparam int CFG_IW = 3;

    localparam int IN_TW  = 9 * CW;
    localparam int OUT_FW = 1 + 4 * QW + 3 * CW;
    localparam int OUT_TW = ((OUT_FW + 7) / 8) * 8;

    localparam logic [CFG_IW-1:0] REG_START_X = CFG_IW'(0);
    localparam logic [CFG_IW-1:0] REG_START_Y = CFG_IW'(1);
    localparam logic [CFG_IW-1:0] REG_START_Z = CFG_IW'(2);
    localparam logic [CFG_IW-1:0] REG_END_X   = CFG_IW'(3);
    localparam logic [CFG_IW-1:0] REG_END_Y   = CFG_IW'(4);
    localparam logic [CFG_IW-1:0] REG_END_Z   = CFG_IW'(5);

    typedef logic [8:0][CW-1:0] t_vtx;     // vertex j axis k at j*3+k
    typedef logic [2:0][CW-1:0] t_point;

    // classified triangle, front to back
    typedef struct packed {
        logic                 hit;
        logic [SW-1:0]        d;
        logic [3:0][SW-1:0]   num;         // t, u, v, w numerators
        t_vtx                 vtx;
    } t_cls;

    typedef struct packed {
        logic                 hit;
        logic [3:0][QW-1:0]   frac;        // t, u, v, w
        t_point               pt;
    } t_res;

endpackage

`default_nettype wire

### rtl/core/sti_queue.sv
// ----------------------------------------------------------------------------
// sti_queue
// short fifo between the classifier and the divider pipeline
// ----------------------------------------------------------------------------
`default_nettype none

module sti_queue import sti_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cls i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cls o_head
);

    t_cls             r_mem [QDEPTH];
    logic [QAW-1:0]   r_wp;
    logic [QAW-1:0]   r_rp;
    logic [QAW:0]     r_cnt;

    assign o_full  = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            if (i_push && !i_pop)      r_cnt <= r_cnt + 1'b1;
            else if (!i_push && i_pop) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

endmodule

`default_nettype wire

### rtl/core/sti_front.sv
// ----------------------------------------------------------------------------
// sti_front
// edge vectors, normal, dot products and the inside test
// ----------------------------------------------------------------------------
`default_nettype none

module sti_front import sti_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_vtx   i_vtx,
    input  t_point i_p,
    input  t_point i_q,
    output logic   o_push,
    input  logic   i_full,
    output t_cls   o_cls
);

    logic [5:0] r_vld;
    logic       w_en;

    logic signed [DW-1:0]  r1_ab [3], r1_ac [3], r1_ap [3], r1_qp [3];
    logic signed [DW-1:0]  r2_ab [3], r2_ac [3], r2_ap [3], r2_qp [3];
    logic signed [DW-1:0]  r3_ab [3], r3_ac [3], r3_ap [3], r3_qp [3];
    logic signed [PW-1:0]  r2_pn [6], r2_pe [6];
    logic signed [NW-1:0]  r3_n [3], r3_e [3];
    logic signed [PLW-1:0] r4_plo [12];
    logic signed [PHW-1:0] r4_phi [12];
    logic signed [PRW-1:0] r5_pr [12];
    logic signed [SW-1:0]  r6_dot [4];
    t_vtx                  r_vtx [6];

    logic signed [DW-1:0]  w_a [12];
    logic signed [NW-1:0]  w_b [12];

    logic signed [SW+1:0]  w_d, w_t, w_v, w_w, w_u;

    assign o_push  = r_vld[5] && !i_full;
    assign w_en    = !r_vld[5] || !i_full;
    assign o_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[4:0], i_valid};
        end
    end

    // dot term operands: d = qp.n, t = ap.n, v = ac.e, -w = ab.e
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_a[k]     = r3_qp[k];  w_b[k]     = r3_n[k];
            w_a[3 + k] = r3_ap[k];  w_b[3 + k] = r3_n[k];
            w_a[6 + k] = r3_ac[k];  w_b[6 + k] = r3_e[k];
            w_a[9 + k] = r3_ab[k];  w_b[9 + k] = r3_e[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // stage 1: differences
            for (int k = 0; k < 3; k++) begin
                r1_ab[k] <= DW'($signed(i_vtx[3 + k])) - DW'($signed(i_vtx[k]));
                r1_ac[k] <= DW'($signed(i_vtx[6 + k])) - DW'($signed(i_vtx[k]));
                r1_ap[k] <= DW'($signed(i_p[k])) - DW'($signed(i_vtx[k]));
                r1_qp[k] <= DW'($signed(i_p[k])) - DW'($signed(i_q[k]));
            end
            r_vtx[0] <= i_vtx;
            // stage 2: cross product terms
            r2_pn[0] <= r1_ab[1] * r1_ac[2];
            r2_pn[1] <= r1_ab[2] * r1_ac[1];
            r2_pn[2] <= r1_ab[2] * r1_ac[0];
            r2_pn[3] <= r1_ab[0] * r1_ac[2];
            r2_pn[4] <= r1_ab[0] * r1_ac[1];
            r2_pn[5] <= r1_ab[1] * r1_ac[0];
            r2_pe[0] <= r1_qp[1] * r1_ap[2];
            r2_pe[1] <= r1_qp[2] * r1_ap[1];
            r2_pe[2] <= r1_qp[2] * r1_ap[0];
            r2_pe[3] <= r1_qp[0] * r1_ap[2];
            r2_pe[4] <= r1_qp[0] * r1_ap[1];
            r2_pe[5] <= r1_qp[1] * r1_ap[0];
            r2_ab <= r1_ab;  r2_ac <= r1_ac;  r2_ap <= r1_ap;  r2_qp <= r1_qp;
            // stage 3: normal and e
            for (int k = 0; k < 3; k++) begin
                r3_n[k] <= NW'(r2_pn[2*k]) - NW'(r2_pn[2*k + 1]);
                r3_e[k] <= NW'(r2_pe[2*k]) - NW'(r2_pe[2*k + 1]);
            end
            r3_ab <= r2_ab;  r3_ac <= r2_ac;  r3_ap <= r2_ap;  r3_qp <= r2_qp;
            // stage 4: split products, low slice unsigned
            for (int m = 0; m < 12; m++) begin
                r4_plo[m] <= w_a[m] * $signed({1'b0, w_b[m][SPLIT-1:0]});
                r4_phi[m] <= w_a[m] * $signed(w_b[m][NW-1:SPLIT]);
            end
            // stage 5: recombine
            for (int m = 0; m < 12; m++) begin
                r5_pr[m] <= (PRW'(r4_phi[m]) <<< SPLIT) + PRW'(r4_plo[m]);
            end
            // stage 6: sums
            for (int j = 0; j < 4; j++) begin
                r6_dot[j] <= SW'(r5_pr[3*j]) + SW'(r5_pr[3*j + 1]) + SW'(r5_pr[3*j + 2]);
            end
            for (int s = 1; s < 6; s++) begin
                r_vtx[s] <= r_vtx[s - 1];
            end
        end
    end

    // inside test, bounds inclusive
    always_comb begin
        w_d = (SW+2)'(r6_dot[0]);
        w_t = (SW+2)'(r6_dot[1]);
        w_v = (SW+2)'(r6_dot[2]);
        w_w = -(SW+2)'(r6_dot[3]);
        w_u = w_d - w_v - w_w;
        o_cls.hit = (w_d > 0) && (w_t >= 0) && (w_t <= w_d) && (w_v >= 0)
                 && (w_v <= w_d) && (w_w >= 0) && (w_u >= 0);
        o_cls.d      = w_d[SW-1:0];
        o_cls.num[0] = w_t[SW-1:0];
        o_cls.num[1] = w_u[SW-1:0];
        o_cls.num[2] = w_v[SW-1:0];
        o_cls.num[3] = w_w[SW-1:0];
        o_cls.vtx    = r_vtx[5];
    end

endmodule

`default_nettype wire

### rtl/core/sti_back.sv
// ----------------------------------------------------------------------------
// sti_back
// pipelined restoring divide and hit point interpolation
// ----------------------------------------------------------------------------
`default_nettype none

module sti_back import sti_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_pop,
    input  t_cls i_cls,
    output logic o_valid,
    input  logic i_ready,
    output t_res o_res
);

    localparam logic signed [HSW-1:0] PT_MAX = $signed({{(HSW-CW+1){1'b0}}, {(CW-1){1'b1}}});
    localparam logic signed [HSW-1:0] PT_MIN = -PT_MAX - HSW'(1);

    logic w_en;

    logic [NSTEP-1:0]        r_vd;
    logic [NSTEP-1:0]        r_hit;
    logic [SW-1:0]           r_dv  [NSTEP];
    t_vtx                    r_vtx [NSTEP];
    logic [3:0][SW-1:0]      r_rem [NSTEP];
    logic [3:0][QW-1:0]      r_q   [NSTEP];
    logic [3:0][SW-1:0]      n_rem [NSTEP];
    logic [3:0][QW-1:0]      n_q   [NSTEP];

    logic                    r_h1_vld, r_h1_hit;
    logic [3:0][QW-1:0]      r_h1_q;
    logic signed [HPW-1:0]   r_h1_p [3][3];
    logic                    r_h2_vld, r_h2_hit;
    logic [3:0][QW-1:0]      r_h2_q;
    logic signed [HSW-1:0]   r_h2_s [3];
    logic                    r_ovld;
    t_res                    r_res;
    logic signed [HSW-1:0]   w_sh [3];

    assign w_en    = !r_ovld || i_ready;
    assign o_pop   = w_en && i_valid;
    assign o_valid = r_ovld;
    assign o_res   = r_res;

    // one quotient bit per stage
    for (genvar s = 0; s < NSTEP; s++) begin : g_div
        logic [SW-1:0]         w_dd;
        logic [3:0][SW-1:0]    w_x;
        logic [3:0][QW-1:0]    w_qin;
        if (s == 0) begin : g_first
            assign w_dd  = i_cls.d;
            assign w_x   = i_cls.num;
            assign w_qin = '0;
        end else begin : g_next
            assign w_dd  = r_dv[s - 1];
            assign w_qin = r_q[s - 1];
            for (genvar j = 0; j < 4; j++) begin : g_sh
                assign w_x[j] = {r_rem[s - 1][j][SW-2:0], 1'b0};
            end
        end
        always_comb begin
            for (int j = 0; j < 4; j++) begin
                if (w_x[j] >= w_dd) begin
                    n_rem[s][j] = w_x[j] - w_dd;
                    n_q[s][j]   = {w_qin[j][QW-2:0], 1'b1};
                end else begin
                    n_rem[s][j] = w_x[j];
                    n_q[s][j]   = {w_qin[j][QW-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vd     <= '0;
            r_h1_vld <= 1'b0;
            r_h2_vld <= 1'b0;
            r_ovld   <= 1'b0;
        end else if (w_en) begin
            r_vd     <= {r_vd[NSTEP-2:0], i_valid};
            r_h1_vld <= r_vd[NSTEP-1];
            r_h2_vld <= r_h1_vld;
            r_ovld   <= r_h2_vld;
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_sh[k] = r_h2_s[k] >>> FB;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_hit[0] <= i_cls.hit;
            r_dv[0]  <= i_cls.d;
            r_vtx[0] <= i_cls.vtx;
            for (int s = 1; s < NSTEP; s++) begin
                r_hit[s] <= r_hit[s - 1];
                r_dv[s]  <= r_dv[s - 1];
                r_vtx[s] <= r_vtx[s - 1];
            end
            for (int s = 0; s < NSTEP; s++) begin
                r_rem[s] <= n_rem[s];
                r_q[s]   <= n_q[s];
            end
            // weights u, v, w sit at quotient slots one to three
            r_h1_hit <= r_hit[NSTEP-1];
            r_h1_q   <= r_q[NSTEP-1];
            for (int k = 0; k < 3; k++) begin
                for (int j = 0; j < 3; j++) begin
                    r_h1_p[k][j] <= $signed(r_vtx[NSTEP-1][3*j + k])
                                  * $signed({1'b0, r_q[NSTEP-1][j + 1]});
                end
            end
            r_h2_hit <= r_h1_hit;
            r_h2_q   <= r_h1_q;
            for (int k = 0; k < 3; k++) begin
                r_h2_s[k] <= HSW'(r_h1_p[k][0]) + HSW'(r_h1_p[k][1]) + HSW'(r_h1_p[k][2]);
            end
            // saturate, zero on a miss
            r_res.hit  <= r_h2_hit;
            r_res.frac <= r_h2_hit ? r_h2_q : '0;
            for (int k = 0; k < 3; k++) begin
                if (!r_h2_hit)            r_res.pt[k] <= '0;
                else if (w_sh[k] > PT_MAX) r_res.pt[k] <= PT_MAX[CW-1:0];
                else if (w_sh[k] < PT_MIN) r_res.pt[k] <= PT_MIN[CW-1:0];
                else                       r_res.pt[k] <= w_sh[k][CW-1:0];
            end
        end
    end

endmodule

`default_nettype wire

### rtl/core/segment_triangle_intersect.sv
// ----------------------------------------------------------------------------
// segment_triangle_intersect
// front-face segment / triangle test with barycentric hit point
// ----------------------------------------------------------------------------
// Takes one triangle per clock, unless the queue is full and the front stalls,
// against a segment held in six configuration registers and returns one
// result per triangle, in order. A triangle passes through six front
// stages (differences, cross products, normal, split dot-product multiplies,
// recombine, sums), the inside test on the way into a four-entry queue, a
// seventeen-stage restoring divider that yields one quotient bit per stage
// for t, u, v and w at once, and three stages for the weighted vertex sum,
// shift and saturation into the output register. Sustained rate is one
// triangle per cycle while results are taken; the queue lets the divider
// side stall on the output without holding up requests already past the front.
// Misses (back face, parallel or degenerate, t or the weights outside their
// bounds) return all fields zero. Write the segment registers only while no triangle is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_triangle_intersect import sti_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // triangle requests
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // vert0_x, vert0_y, vert0_z, vert1_x .. vert2_z, 32 bits each
    input  logic [IN_TW-1:0]  s_axis_tdata,
    // results
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // hit, param_t, bary_u, bary_v, bary_w (17 each), hit_x, hit_y, hit_z, pad
    output logic [OUT_TW-1:0] m_axis_tdata,
    // segment register writes
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CFG_IW-1:0] i_cfg_index,
    input  logic [CW-1:0]     i_cfg_data
);

    logic [CW-1:0] r_seg [NREG];   // start x,y,z then end x,y,z

    t_vtx   w_vtx;
    t_point w_p, w_q;
    t_cls   w_cls_in, w_cls_out;
    logic   w_push, w_full, w_pop, w_qvalid;
    t_res   w_res;

    assign o_cfg_ready = 1'b1;

    // segment registers, unknown indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NREG; i++) r_seg[i] <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_START_X: r_seg[0] <= i_cfg_data;
                REG_START_Y: r_seg[1] <= i_cfg_data;
                REG_START_Z: r_seg[2] <= i_cfg_data;
                REG_END_X:   r_seg[3] <= i_cfg_data;
                REG_END_Y:   r_seg[4] <= i_cfg_data;
                REG_END_Z:   r_seg[5] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // unpack request
    for (genvar i = 0; i < 9; i++) begin : g_in
        assign w_vtx[i] = s_axis_tdata[i*CW +: CW];
    end
    for (genvar k = 0; k < 3; k++) begin : g_seg
        assign w_p[k] = r_seg[k];
        assign w_q[k] = r_seg[3 + k];
    end

    // classify side
    sti_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_vtx   (w_vtx),
        .i_p     (w_p),
        .i_q     (w_q),
        .o_push  (w_push),
        .i_full  (w_full),
        .o_cls   (w_cls_in)
    );

    // decouples the two sides
    sti_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_cls_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_qvalid),
        .o_head  (w_cls_out)
    );

    // divide and interpolate side
    sti_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_qvalid),
        .o_pop   (w_pop),
        .i_cls   (w_cls_out),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (w_res)
    );

    // pack result, hit in bit zero
    assign m_axis_tdata = {(OUT_TW - OUT_FW)'(0), w_res.pt[2], w_res.pt[1], w_res.pt[0],
                           w_res.frac[3], w_res.frac[2], w_res.frac[1], w_res.frac[0],
                           w_res.hit};

endmodule

`default_nettype wire

### rtl/core/sti_checker.sv
// ----------------------------------------------------------------------------
// sti_checker
// port-level checks on the result stream
// ----------------------------------------------------------------------------
`default_nettype none
`include "segment_triangle_intersect_defines.svh"

module sti_checker import sti_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic [OUT_TW-1:0] m_axis_tdata
);

    localparam logic [QW+1:0] ONE = (QW+2)'(1) << FB;

    logic          w_stall;
    logic          w_res_hit;
    logic          w_res_miss;
    logic          w_rest_zero;
    logic          w_wsum_ok;
    logic [QW+1:0] w_wsum;

    assign w_stall     = m_axis_tvalid && !m_axis_tready;
    assign w_res_hit   = m_axis_tvalid && m_axis_tdata[0];
    assign w_res_miss  = m_axis_tvalid && !m_axis_tdata[0];
    assign w_rest_zero = (m_axis_tdata[OUT_TW-1:1] == '0);
    assign w_wsum  = (QW+2)'(m_axis_tdata[1 + QW +: QW])
                   + (QW+2)'(m_axis_tdata[1 + 2*QW +: QW])
                   + (QW+2)'(m_axis_tdata[1 + 3*QW +: QW]);
    assign w_wsum_ok   = (w_wsum <= ONE) && (w_wsum >= ONE - (QW+2)'(2));

    `STI_ASSERT_NEXT(a_valid_held, w_stall, m_axis_tvalid, "result dropped while stalled")
    `STI_ASSERT_NEXT(a_data_held, w_stall, $stable(m_axis_tdata), "result changed while stalled")
    `STI_ASSERT(a_miss_zero, w_res_miss, w_rest_zero, "miss with nonzero fields")
    `STI_ASSERT(a_weights, w_res_hit, w_wsum_ok, "barycentric weights do not sum to one")

endmodule

bind segment_triangle_intersect sti_checker u_sti_checker (.*);

`default_nettype wire
